### rtl/core/edcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edcr_pkg
// Types, widths and helpers shared by the disc collision response core.
// ----------------------------------------------------------------------------
package edcr_pkg;

	localparam int VW    = 32;          // velocity / position width
	localparam int DW    = VW + 1;      // coordinate difference
	localparam int MW    = VW;          // magnitude of a difference
	localparam int PW    = 2 * MW;      // product of two magnitudes
	localparam int DOTW  = PW + 1;      // dot product magnitude, dd
	localparam int MASSW = 16;
	localparam int MSW   = MASSW + 1;   // mass sum, doubled mass
	localparam int XW    = DOTW + MW;   // dot times component
	localparam int NUMW  = XW + MSW;    // dividend
	localparam int DENW  = DOTW + MSW;  // divisor
	localparam int QW    = 36;          // quotient bits (change below 2^34)
	localparam int SUMW  = QW + 2;      // velocity plus change
	localparam int PPW   = 50;          // partial product of numerator
	localparam int LANES = 4;
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [VW-1:0]    first_pos_x;
		logic [VW-1:0]    first_pos_y;
		logic [VW-1:0]    second_pos_x;
		logic [VW-1:0]    second_pos_y;
		logic [VW-1:0]    first_vel_x;
		logic [VW-1:0]    first_vel_y;
		logic [VW-1:0]    second_vel_x;
		logic [VW-1:0]    second_vel_y;
		logic [MASSW-1:0] first_mass;
		logic [MASSW-1:0] second_mass;
	} pair_item_t;

	typedef struct packed {
		logic [VW-1:0] new_first_vel_x;
		logic [VW-1:0] new_first_vel_y;
		logic [VW-1:0] new_second_vel_x;
		logic [VW-1:0] new_second_vel_y;
		logic          bounced;
		logic          coincident;
	} resp_item_t;

	typedef struct packed {
		logic [VW-1:0] v1x;
		logic [VW-1:0] v1y;
		logic [VW-1:0] v2x;
		logic [VW-1:0] v2y;
	} vel_t;

	// lanes: first x, first y, second x, second y
	typedef struct packed {
		logic [LANES-1:0] chneg;
		logic             bounced;
		logic             coincident;
		vel_t             vel;
	} meta_t;

	typedef struct packed {
		logic [LANES-1:0][NUMW-1:0] num;
		logic [DENW-1:0]            den;
		meta_t                      meta;
	} work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [MW-1:0] mag_diff(input logic [DW-1:0] a);
		logic [DW-1:0] n;
		n = -a;
		return a[DW-1] ? n[MW-1:0] : a[MW-1:0];
	endfunction

	function automatic logic [VW-1:0] sat_vel(input logic [SUMW-1:0] a);
		if (!a[SUMW-1] && (|a[SUMW-2:VW-1]))
			return {1'b0, {(VW-1){1'b1}}};
		else if (a[SUMW-1] && !(&a[SUMW-2:VW-1]))
			return {1'b1, {(VW-1){1'b0}}};
		else
			return a[VW-1:0];
	endfunction

endpackage
`default_nettype wire

### rtl/core/elastic_disc_collision_response_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// elastic_disc_collision_response_core
// Elastic response of one colliding pair of discs per item.
//
// The pair channel (pair_valid, pair_stall, pair) takes both centres,
// velocities and masses; the resp channel (resp_valid, resp_stall, resp)
// returns the four new velocity components and the bounced and coincident
// flags, one result item per pair item, in order.
// A new pair can be taken every cycle while pair_stall is low. An item passes
// through seven front stages that form d, dot, dd and the dividends, a
// four-entry queue, then a 36-stage divider that retires one quotient bit per
// stage; the last stage saturates into the output register.
// When resp_stall is high while resp_valid is high, the back part holds; the
// queue then fills, and pair_stall rises once it is full and s7 holds a pair.
// Reset clears all valid flags and the queue; no item is in flight after.
// ----------------------------------------------------------------------------
module elastic_disc_collision_response_core #(
	parameter int QUEUE_DEPTH = edcr_pkg::QUEUE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 pair_valid,
	output logic                      pair_stall,
	input  wire edcr_pkg::pair_item_t pair,
	output logic                      resp_valid,
	input  wire logic                 resp_stall,
	output edcr_pkg::resp_item_t      resp
);

	edcr_pkg::q_status_t qstat;
	edcr_pkg::work_t     wdata, rdata;
	logic                push, pop;

	edcr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_valid (pair_valid),
		.pair_stall (pair_stall),
		.pair       (pair),
		.qstat      (qstat),
		.push       (push),
		.wdata      (wdata)
	);

	edcr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wdata),
		.pop    (pop),
		.rdata  (rdata),
		.qstat  (qstat)
	);

	edcr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.rdata      (rdata),
		.pop        (pop),
		.resp_valid (resp_valid),
		.resp_stall (resp_stall),
		.resp       (resp)
	);

endmodule
`default_nettype wire

### rtl/core/edcr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edcr_front
// Accepts pairs, forms d, dot and dd, classifies the pair and builds the
// dividends and divisor of the four velocity changes.
// ----------------------------------------------------------------------------
module edcr_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 pair_valid,
	output logic                      pair_stall,
	input  wire edcr_pkg::pair_item_t pair,
	input  wire edcr_pkg::q_status_t  qstat,
	output logic                      push,
	output edcr_pkg::work_t           wdata
);

	localparam int VW   = edcr_pkg::VW;
	localparam int DW   = edcr_pkg::DW;
	localparam int MW   = edcr_pkg::MW;
	localparam int PW   = edcr_pkg::PW;
	localparam int DOTW = edcr_pkg::DOTW;
	localparam int MSW  = edcr_pkg::MSW;
	localparam int MASSW = edcr_pkg::MASSW;
	localparam int XW   = edcr_pkg::XW;
	localparam int NUMW = edcr_pkg::NUMW;
	localparam int DENW = edcr_pkg::DENW;
	localparam int PPW  = edcr_pkg::PPW;

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	assign en         = !(vld_s7 && qstat.full);
	assign pair_stall = !en;
	assign push       = vld_s7 && !qstat.full;

	// s1
	logic [DW-1:0]     dx_s1, dy_s1, dvx_s1, dvy_s1;
	logic [MASSW-1:0]  m1_s1, m2_s1;
	edcr_pkg::vel_t    vel_s1;
	// s2
	logic [PW-1:0]     pdx_s2, pdy_s2, dxx_s2, dyy_s2;
	logic              sdx_s2, sdy_s2, sgx_s2, sgy_s2, coinc_s2;
	logic [MW-1:0]     mdx_s2, mdy_s2;
	logic [MSW-1:0]    msum_s2;
	logic [MASSW-1:0]  m1_s2, m2_s2;
	edcr_pkg::vel_t    vel_s2;
	// s3
	logic [DOTW-1:0]   dot_s3, dd_s3;
	logic              chx_s3, chy_s3, bnc_s3, coinc_s3;
	logic [MW-1:0]     mdx_s3, mdy_s3;
	logic [MSW-1:0]    msum_s3;
	logic [MASSW-1:0]  m1_s3, m2_s3;
	edcr_pkg::vel_t    vel_s3;
	// s4
	logic [PW-1:0]     pxl_s4, pyl_s4;
	logic [PW:0]       pxh_s4, pyh_s4;
	logic [MW+MSW-1:0] ddl_s4;
	logic [MW+MSW:0]   ddh_s4;
	logic              chx_s4, chy_s4, bnc_s4, coinc_s4;
	logic [MASSW-1:0]  m1_s4, m2_s4;
	edcr_pkg::vel_t    vel_s4;
	// s5
	logic [XW-1:0]     px_s5, py_s5;
	logic [DENW-1:0]   den_s5;
	logic              chx_s5, chy_s5, bnc_s5, coinc_s5;
	logic [MASSW-1:0]  m1_s5, m2_s5;
	edcr_pkg::vel_t    vel_s5;
	// s6
	logic [PPW-1:0]    part_s6 [4][3];
	logic [DENW-1:0]   den_s6;
	logic              chx_s6, chy_s6, bnc_s6, coinc_s6;
	edcr_pkg::vel_t    vel_s6;
	// s7
	edcr_pkg::work_t   work_s7;

	// s3 signed sum of the two dot terms
	logic [DOTW-1:0] dot_c;
	logic            neg_c;
	always_comb begin
		if (sdx_s2 == sdy_s2) begin
			dot_c = {1'b0, pdx_s2} + {1'b0, pdy_s2};
			neg_c = sdx_s2;
		end else if (pdx_s2 >= pdy_s2) begin
			dot_c = {1'b0, pdx_s2 - pdy_s2};
			neg_c = sdx_s2;
		end else begin
			dot_c = {1'b0, pdy_s2 - pdx_s2};
			neg_c = sdy_s2;
		end
		if (dot_c == '0)
			neg_c = 1'b0;
	end

	// s6 operands: numerator bases and doubled masses
	logic [XW-1:0]  xsrc [4];
	logic [MSW-1:0] msrc [4];
	always_comb begin
		xsrc[0] = px_s5;  msrc[0] = {m2_s5, 1'b0};
		xsrc[1] = py_s5;  msrc[1] = {m2_s5, 1'b0};
		xsrc[2] = px_s5;  msrc[2] = {m1_s5, 1'b0};
		xsrc[3] = py_s5;  msrc[3] = {m1_s5, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pair_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= {pair.second_pos_x[VW-1], pair.second_pos_x}
				- {pair.first_pos_x[VW-1], pair.first_pos_x};
			dy_s1  <= {pair.second_pos_y[VW-1], pair.second_pos_y}
				- {pair.first_pos_y[VW-1], pair.first_pos_y};
			dvx_s1 <= {pair.second_vel_x[VW-1], pair.second_vel_x}
				- {pair.first_vel_x[VW-1], pair.first_vel_x};
			dvy_s1 <= {pair.second_vel_y[VW-1], pair.second_vel_y}
				- {pair.first_vel_y[VW-1], pair.first_vel_y};
			m1_s1  <= pair.first_mass;
			m2_s1  <= pair.second_mass;
			vel_s1 <= '{v1x: pair.first_vel_x, v1y: pair.first_vel_y,
				v2x: pair.second_vel_x, v2y: pair.second_vel_y};

			pdx_s2   <= edcr_pkg::mag_diff(dvx_s1) * edcr_pkg::mag_diff(dx_s1);
			pdy_s2   <= edcr_pkg::mag_diff(dvy_s1) * edcr_pkg::mag_diff(dy_s1);
			dxx_s2   <= edcr_pkg::mag_diff(dx_s1) * edcr_pkg::mag_diff(dx_s1);
			dyy_s2   <= edcr_pkg::mag_diff(dy_s1) * edcr_pkg::mag_diff(dy_s1);
			sdx_s2   <= dvx_s1[DW-1] ^ dx_s1[DW-1];
			sdy_s2   <= dvy_s1[DW-1] ^ dy_s1[DW-1];
			sgx_s2   <= dx_s1[DW-1];
			sgy_s2   <= dy_s1[DW-1];
			coinc_s2 <= (dx_s1 == '0) && (dy_s1 == '0);
			mdx_s2   <= edcr_pkg::mag_diff(dx_s1);
			mdy_s2   <= edcr_pkg::mag_diff(dy_s1);
			msum_s2  <= {1'b0, m1_s1} + {1'b0, m2_s1};
			m1_s2    <= m1_s1;
			m2_s2    <= m2_s1;
			vel_s2   <= vel_s1;

			dot_s3   <= dot_c;
			dd_s3    <= {1'b0, dxx_s2} + {1'b0, dyy_s2};
			chx_s3   <= neg_c ^ sgx_s2;
			chy_s3   <= neg_c ^ sgy_s2;
			bnc_s3   <= !coinc_s2 && (msum_s2 != '0) && (neg_c || (dot_c == '0));
			coinc_s3 <= coinc_s2;
			mdx_s3   <= mdx_s2;
			mdy_s3   <= mdy_s2;
			msum_s3  <= msum_s2;
			m1_s3    <= m1_s2;
			m2_s3    <= m2_s2;
			vel_s3   <= vel_s2;

			pxl_s4   <= dot_s3[MW-1:0] * mdx_s3;
			pxh_s4   <= dot_s3[DOTW-1:MW] * mdx_s3;
			pyl_s4   <= dot_s3[MW-1:0] * mdy_s3;
			pyh_s4   <= dot_s3[DOTW-1:MW] * mdy_s3;
			ddl_s4   <= dd_s3[MW-1:0] * msum_s3;
			ddh_s4   <= dd_s3[DOTW-1:MW] * msum_s3;
			chx_s4   <= chx_s3;
			chy_s4   <= chy_s3;
			bnc_s4   <= bnc_s3;
			coinc_s4 <= coinc_s3;
			m1_s4    <= m1_s3;
			m2_s4    <= m2_s3;
			vel_s4   <= vel_s3;

			px_s5    <= XW'(pxl_s4) + (XW'(pxh_s4) << MW);
			py_s5    <= XW'(pyl_s4) + (XW'(pyh_s4) << MW);
			den_s5   <= DENW'(ddl_s4) + (DENW'(ddh_s4) << MW);
			chx_s5   <= chx_s4;
			chy_s5   <= chy_s4;
			bnc_s5   <= bnc_s4;
			coinc_s5 <= coinc_s4;
			m1_s5    <= m1_s4;
			m2_s5    <= m2_s4;
			vel_s5   <= vel_s4;

			for (int i = 0; i < 4; i++) begin
				part_s6[i][0] <= PPW'(xsrc[i][MW-1:0] * msrc[i]);
				part_s6[i][1] <= PPW'(xsrc[i][2*MW-1:MW] * msrc[i]);
				part_s6[i][2] <= PPW'(xsrc[i][XW-1:2*MW] * msrc[i]);
			end
			den_s6   <= den_s5;
			chx_s6   <= chx_s5;
			chy_s6   <= chy_s5;
			bnc_s6   <= bnc_s5;
			coinc_s6 <= coinc_s5;
			vel_s6   <= vel_s5;

			for (int i = 0; i < 4; i++)
				work_s7.num[i] <= NUMW'(part_s6[i][0]) + (NUMW'(part_s6[i][1]) << MW)
					+ (NUMW'(part_s6[i][2]) << (2 * MW));
			work_s7.den             <= den_s6;
			work_s7.meta.chneg      <= {chy_s6, chx_s6, chy_s6, chx_s6};
			work_s7.meta.bounced    <= bnc_s6;
			work_s7.meta.coincident <= coinc_s6;
			work_s7.meta.vel        <= vel_s6;
		end
	end

	assign wdata = work_s7;

endmodule
`default_nettype wire

### rtl/core/edcr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edcr_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module edcr_queue #(
	parameter int DEPTH = edcr_pkg::QUEUE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire edcr_pkg::work_t     wdata,
	input  wire logic                pop,
	output edcr_pkg::work_t          rdata,
	output edcr_pkg::q_status_t      qstat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	edcr_pkg::work_t entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign qstat.full  = (count_q == CW'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign rdata       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= wdata;
	end

endmodule
`default_nettype wire

### rtl/core/edcr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edcr_back
// Pipelined restoring division of the four velocity changes, one quotient
// bit per stage, then signed update, saturation and the output register.
// ----------------------------------------------------------------------------
module edcr_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire edcr_pkg::q_status_t qstat,
	input  wire edcr_pkg::work_t     rdata,
	output logic                     pop,
	output logic                     resp_valid,
	input  wire logic                resp_stall,
	output edcr_pkg::resp_item_t     resp
);

	localparam int VW    = edcr_pkg::VW;
	localparam int NUMW  = edcr_pkg::NUMW;
	localparam int DENW  = edcr_pkg::DENW;
	localparam int QW    = edcr_pkg::QW;
	localparam int SUMW  = edcr_pkg::SUMW;
	localparam int LANES = edcr_pkg::LANES;

	logic en;
	logic vld_s [QW+1];
	logic [DENW-1:0]   rem_s [QW+1][LANES];
	logic [QW-1:0]     lo_s  [QW+1][LANES];
	logic [DENW-1:0]   den_s [QW+1];
	edcr_pkg::meta_t   meta_s [QW+1];
	logic [DENW-1:0]   nrem  [QW+1][LANES];
	logic [QW-1:0]     nlo   [QW+1][LANES];
	logic              resp_valid_q;
	edcr_pkg::resp_item_t resp_q;

	assign en         = !(resp_valid_q && resp_stall);
	assign pop        = en && !qstat.empty;
	assign resp_valid = resp_valid_q;
	assign resp       = resp_q;

	always_comb begin
		logic [DENW:0] t;
		for (int l = 0; l < LANES; l++) begin
			nrem[0][l] = '0;
			nlo[0][l]  = '0;
		end
		for (int k = 1; k <= QW; k++) begin
			for (int l = 0; l < LANES; l++) begin
				t = {rem_s[k-1][l], lo_s[k-1][l][QW-1]};
				if (t >= {1'b0, den_s[k-1]}) begin
					nrem[k][l] = DENW'(t - {1'b0, den_s[k-1]});
					nlo[k][l]  = {lo_s[k-1][l][QW-2:0], 1'b1};
				end else begin
					nrem[k][l] = t[DENW-1:0];
					nlo[k][l]  = {lo_s[k-1][l][QW-2:0], 1'b0};
				end
			end
		end
	end

	// final update of the four components
	logic [LANES-1:0][VW-1:0] vin;
	logic [LANES-1:0][VW-1:0] vout;
	always_comb begin
		logic [SUMW-1:0] ch;
		logic [SUMW-1:0] sum;
		vin = {meta_s[QW].vel.v2y, meta_s[QW].vel.v2x,
			meta_s[QW].vel.v1y, meta_s[QW].vel.v1x};
		for (int l = 0; l < LANES; l++) begin
			ch = {2'b00, lo_s[QW][l]};
			if (meta_s[QW].chneg[l])
				ch = -ch;
			if (!meta_s[QW].bounced)
				ch = '0;
			if (l < 2)
				sum = {{(SUMW-VW){vin[l][VW-1]}}, vin[l]} + ch;
			else
				sum = {{(SUMW-VW){vin[l][VW-1]}}, vin[l]} - ch;
			vout[l] = edcr_pkg::sat_vel(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QW; k++)
				vld_s[k] <= 1'b0;
			resp_valid_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= !qstat.empty;
			for (int k = 1; k <= QW; k++)
				vld_s[k] <= vld_s[k-1];
			resp_valid_q <= vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				rem_s[0][l] <= DENW'(rdata.num[l][NUMW-1:QW]);
				lo_s[0][l]  <= rdata.num[l][QW-1:0];
			end
			den_s[0]  <= rdata.den;
			meta_s[0] <= rdata.meta;
			for (int k = 1; k <= QW; k++) begin
				for (int l = 0; l < LANES; l++) begin
					rem_s[k][l] <= nrem[k][l];
					lo_s[k][l]  <= nlo[k][l];
				end
				den_s[k]  <= den_s[k-1];
				meta_s[k] <= meta_s[k-1];
			end
			resp_q.new_first_vel_x  <= vout[0];
			resp_q.new_first_vel_y  <= vout[1];
			resp_q.new_second_vel_x <= vout[2];
			resp_q.new_second_vel_y <= vout[3];
			resp_q.bounced          <= meta_s[QW].bounced;
			resp_q.coincident       <= meta_s[QW].coincident;
		end
	end

endmodule
`default_nettype wire
